// File: sv/burgers_element_jacobian_top_macros.svh
// Assertion macros for the Burgers element Jacobian block.
// Included by the top level; depends on nothing else.
`ifndef BURGERS_ELEMENT_JACOBIAN_TOP_MACROS_SVH
`define BURGERS_ELEMENT_JACOBIAN_TOP_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define BEJ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication into the next cycle, disabled during reset.
`define BEJ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Plain implication that also holds while reset is applied.
`define BEJ_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/bej_pkg.sv
// Package for the Burgers element Jacobian block: types, Gauss constants,
// per-point basis tables and the rounding and saturation helpers. No dependencies.
package bej_pkg;

   localparam int NumPts    = 16;
   localparam int QueueDepth = 2;
   localparam int FracC     = 30;
   localparam int FracV     = 16;

   typedef logic [3:0][29:0] phi_row_type;

   typedef logic [29:0] absc_arr_type [4];
   localparam absc_arr_type ABSC  = '{30'd74551875, 30'd354344979,
                                      30'd719396845, 30'd999189949};
   localparam absc_arr_type GWGHT = '{30'd373506296, 30'd700235528,
                                      30'd700235528, 30'd373506296};

   // One element as held in the queue, with the two x-differences precomputed.
   typedef struct packed {
      logic signed [31:0] u0;
      logic signed [31:0] u1;
      logic signed [31:0] u2;
      logic signed [31:0] u3;
      logic signed [32:0] dux0;
      logic signed [32:0] dux1;
      logic [30:0]        dur;
   } elem_type;

   // Saturated entries handed from the accumulators to the output bank.
   typedef struct packed {
      logic              load;
      logic [15:0][31:0] vals;
   } bank_load_type;

   // Round to nearest, ties away from zero, by a constant shift.
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
      logic [63:0] m;
      m = v[63] ? (64'd0 - v) : v;
      m = (m + (64'd1 << (s - 1))) >> s;
      return v[63] ? $signed(64'd0 - m) : $signed(m);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // Elaboration-time rounding of a product of two Q0.30 constants.
   function automatic logic [29:0] cmul(input logic [29:0] a, input logic [29:0] b);
      logic [63:0] p;
      p = 64'(a) * 64'(b);
      p = (p + (64'd1 << (FracC - 1))) >> FracC;
      return p[29:0];
   endfunction

   function automatic phi_row_type phi_row(input int pt);
      phi_row_type r;
      int i;
      int j;
      i = pt / 4;
      j = pt % 4;
      r[0] = cmul(ABSC[3 - i], ABSC[3 - j]);
      r[1] = cmul(ABSC[i], ABSC[3 - j]);
      r[2] = cmul(ABSC[i], ABSC[j]);
      r[3] = cmul(ABSC[3 - i], ABSC[j]);
      return r;
   endfunction

   function automatic logic [29:0] w_of(input int pt);
      return cmul(GWGHT[pt / 4], GWGHT[pt % 4]);
   endfunction

   typedef phi_row_type phi_tab_type [16];
   typedef logic [29:0] w_tab_type [16];

   localparam phi_tab_type PHI_TAB = '{
      phi_row(0), phi_row(1), phi_row(2), phi_row(3),
      phi_row(4), phi_row(5), phi_row(6), phi_row(7),
      phi_row(8), phi_row(9), phi_row(10), phi_row(11),
      phi_row(12), phi_row(13), phi_row(14), phi_row(15)};

   localparam w_tab_type W_TAB = '{
      w_of(0), w_of(1), w_of(2), w_of(3), w_of(4), w_of(5), w_of(6), w_of(7),
      w_of(8), w_of(9), w_of(10), w_of(11), w_of(12), w_of(13), w_of(14), w_of(15)};

endpackage

// File: sv/bej_ifs.sv
// Channel interfaces of the Burgers element Jacobian block.
// Stand-alone; the field widths follow the element and entry formats.
interface bej_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] node_u0;
   logic signed [31:0] node_u1;
   logic signed [31:0] node_u2;
   logic signed [31:0] node_u3;
   logic [30:0]        elem_width;
   logic [30:0]        elem_duration;

   modport source(output valid, node_u0, node_u1, node_u2, node_u3, elem_width,
                  elem_duration, input ready);
   modport sink(input valid, node_u0, node_u1, node_u2, node_u3, elem_width,
                elem_duration, output ready);
endinterface

interface bej_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         row;
   logic [1:0]         col;
   logic signed [31:0] entry_value;
   logic               last;

   modport source(output valid, row, col, entry_value, last, input ready);
   modport sink(input valid, row, col, entry_value, last, output ready);
endinterface

// File: sv/bej_front.sv
// Front end: accepts element words into a two-entry queue and precomputes
// the nodal x-differences. Depends on bej_pkg and bej_ifs.
module bej_front #(
   parameter int Depth = bej_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   bej_req_if.sink           req_ch,
   input  logic              pop,
   output logic              q_valid,
   output bej_pkg::elem_type q_elem
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   bej_pkg::elem_type  mem_ff [Depth];
   logic [PtrW-1:0]    head_ff, head_in;
   logic [PtrW-1:0]    tail_ff, tail_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               push;
   bej_pkg::elem_type  new_elem;

   // The element width cancels out of the Jacobian and is not stored.
   always_comb begin
      new_elem.u0   = req_ch.node_u0;
      new_elem.u1   = req_ch.node_u1;
      new_elem.u2   = req_ch.node_u2;
      new_elem.u3   = req_ch.node_u3;
      new_elem.dux0 = 33'(req_ch.node_u1) - 33'(req_ch.node_u0);
      new_elem.dux1 = 33'(req_ch.node_u2) - 33'(req_ch.node_u3);
      new_elem.dur  = req_ch.elem_duration;
   end

   assign req_ch.ready = (count_ff != CntW'(Depth));
   assign push    = req_ch.valid && req_ch.ready;
   assign q_valid = (count_ff != '0);
   assign q_elem  = mem_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PtrW'(Depth - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PtrW'(Depth - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push) mem_ff[tail_ff] <= new_elem;
   end

endmodule

// File: sv/bej_back.sv
// Back end: seven-stage pipeline, one Gauss point per cycle unless stalled;
// sums the 16 weighted products per point into 16 accumulators. Uses bej_pkg.
module bej_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  bej_pkg::elem_type      q_elem,
   output logic                   pop,
   input  logic                   bank_free,
   output bej_pkg::bank_load_type bank_ld,
   output logic                   adv
);

   logic [3:0] pt_ff, pt_in;
   logic       issue;

   // Stage 1: raw products of the point.
   logic                     v1_ff;
   logic [3:0]               pt1_ff;
   logic signed [63:0]       pu_ff [4];
   logic signed [63:0]       pd_ff [2];
   logic [61:0]              pk_ff;
   // Stage 2: u, du/dx and the point factor K.
   logic                     v2_ff;
   logic [3:0]               pt2_ff;
   logic signed [31:0]       uv_ff, d_ff;
   logic [29:0]              k2_ff;
   // Stage 3: raw products of c.
   logic                     v3_ff;
   logic [3:0]               pt3_ff;
   logic [29:0]              k3_ff;
   logic signed [63:0]       cphi_ff [4];
   logic signed [63:0]       cug_ff [4];
   // Stage 4: c per trial node.
   logic                     v4_ff;
   logic [3:0]               pt4_ff;
   logic [29:0]              k4_ff;
   logic signed [31:0]       c_ff [4];
   // Stage 5: raw phi_a * c_b.
   logic                     v5_ff;
   logic [3:0]               pt5_ff;
   logic [29:0]              k5_ff;
   logic signed [63:0]       pr_ff [16];
   // Stage 6: rounded p.
   logic                     v6_ff;
   logic [3:0]               pt6_ff;
   logic [29:0]              k6_ff;
   logic signed [33:0]       p_ff [16];
   // Stage 7: raw p * K.
   logic                     v7_ff;
   logic [3:0]               pt7_ff;
   logic signed [63:0]       pkr_ff [16];

   logic signed [63:0]       acc_ff [16];
   logic signed [63:0]       acc_in [16];
   logic [29:0]              ct, st;
   logic                     last7;

   bej_pkg::phi_row_type     phi0, phi3, phi5;
   logic signed [30:0]       g3 [4];

   assign last7 = (pt7_ff == 4'(bej_pkg::NumPts - 1));
   assign adv   = !(v7_ff && last7 && !bank_free);
   assign issue = adv && q_valid;
   assign pop   = issue && (pt_ff == 4'(bej_pkg::NumPts - 1));
   assign pt_in = issue ? pt_ff + 1'b1 : pt_ff;

   assign phi0 = bej_pkg::PHI_TAB[pt_ff];
   assign phi3 = bej_pkg::PHI_TAB[pt2_ff];
   assign phi5 = bej_pkg::PHI_TAB[pt4_ff];
   assign ct   = bej_pkg::ABSC[~pt2_ff[1:0]];
   assign st   = bej_pkg::ABSC[pt2_ff[1:0]];

   always_comb begin
      g3[0] = -$signed({1'b0, ct});
      g3[1] = $signed({1'b0, ct});
      g3[2] = $signed({1'b0, st});
      g3[3] = -$signed({1'b0, st});
   end

   always_comb begin
      for (int n = 0; n < 16; n++) begin
         acc_in[n] = ((pt7_ff == 4'd0) ? 64'sd0 : acc_ff[n])
                     + bej_pkg::rnd_shift(pkr_ff[n], bej_pkg::FracV);
      end
   end

   always_comb begin
      bank_ld.load = adv && v7_ff && last7;
      for (int n = 0; n < 16; n++) begin
         bank_ld.vals[n] = bej_pkg::sat32(acc_in[n]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         pt_ff <= pt_in;
         if (adv) begin
            v1_ff <= issue;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
            v5_ff <= v4_ff;
            v6_ff <= v5_ff;
            v7_ff <= v6_ff;
         end
      end
      if (adv) begin
         pt1_ff   <= pt_ff;
         pu_ff[0] <= q_elem.u0 * $signed({1'b0, phi0[0]});
         pu_ff[1] <= q_elem.u1 * $signed({1'b0, phi0[1]});
         pu_ff[2] <= q_elem.u2 * $signed({1'b0, phi0[2]});
         pu_ff[3] <= q_elem.u3 * $signed({1'b0, phi0[3]});
         pd_ff[0] <= q_elem.dux0 * $signed({1'b0, bej_pkg::ABSC[~pt_ff[1:0]]});
         pd_ff[1] <= q_elem.dux1 * $signed({1'b0, bej_pkg::ABSC[pt_ff[1:0]]});
         pk_ff    <= 62'(bej_pkg::W_TAB[pt_ff]) * 62'(q_elem.dur);

         pt2_ff <= pt1_ff;
         uv_ff  <= bej_pkg::sat32(bej_pkg::rnd_shift(
                      pu_ff[0] + pu_ff[1] + pu_ff[2] + pu_ff[3], bej_pkg::FracC));
         d_ff   <= bej_pkg::sat32(bej_pkg::rnd_shift(pd_ff[0] + pd_ff[1],
                                                      bej_pkg::FracC));
         k2_ff  <= 30'((pk_ff + (62'd1 << (bej_pkg::FracC + 1))) >> (bej_pkg::FracC + 2));

         pt3_ff <= pt2_ff;
         k3_ff  <= k2_ff;
         for (int b = 0; b < 4; b++) begin
            cphi_ff[b] <= d_ff * $signed({1'b0, phi3[b]});
            cug_ff[b]  <= uv_ff * g3[b];
         end

         pt4_ff <= pt3_ff;
         k4_ff  <= k3_ff;
         for (int b = 0; b < 4; b++) begin
            c_ff[b] <= bej_pkg::sat32(bej_pkg::rnd_shift(cphi_ff[b] + cug_ff[b],
                                                         bej_pkg::FracC));
         end

         pt5_ff <= pt4_ff;
         k5_ff  <= k4_ff;
         for (int n = 0; n < 16; n++) begin
            pr_ff[n] <= c_ff[n % 4] * $signed({1'b0, phi5[n / 4]});
         end

         pt6_ff <= pt5_ff;
         k6_ff  <= k5_ff;
         for (int n = 0; n < 16; n++) begin
            p_ff[n] <= 34'(bej_pkg::rnd_shift(pr_ff[n], bej_pkg::FracC));
         end

         pt7_ff <= pt6_ff;
         for (int n = 0; n < 16; n++) begin
            pkr_ff[n] <= p_ff[n] * $signed({1'b0, k6_ff});
         end

         if (v7_ff) begin
            for (int n = 0; n < 16; n++) acc_ff[n] <= acc_in[n];
         end
      end
   end

endmodule

// File: sv/bej_drain.sv
// Output bank: holds the 16 finished entries of one element and sends them
// one word per ready cycle in row-major order. Uses bej_pkg and bej_ifs.
module bej_drain (
   input  logic                   clock,
   input  logic                   reset,
   input  bej_pkg::bank_load_type bank_ld,
   output logic                   bank_free,
   bej_rsp_if.source              rsp_ch
);

   logic [15:0][31:0] vals_ff;
   logic              bank_v_ff, bank_v_in;
   logic [3:0]        idx_ff, idx_in;
   logic              fire;
   logic              at_end;

   assign fire      = rsp_ch.valid && rsp_ch.ready;
   assign at_end    = (idx_ff == 4'd15);
   assign bank_free = !bank_v_ff || (fire && at_end);

   assign rsp_ch.valid       = bank_v_ff;
   assign rsp_ch.row         = idx_ff[3:2];
   assign rsp_ch.col         = idx_ff[1:0];
   assign rsp_ch.entry_value = vals_ff[idx_ff];
   assign rsp_ch.last        = at_end;

   always_comb begin
      bank_v_in = bank_v_ff;
      idx_in    = idx_ff;
      if (bank_ld.load) begin
         bank_v_in = 1'b1;
         idx_in    = '0;
      end else if (fire) begin
         idx_in = idx_ff + 1'b1;
         if (at_end) bank_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_v_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         bank_v_ff <= bank_v_in;
         idx_ff    <= idx_in;
      end
      if (bank_ld.load) vals_ff <= bank_ld.vals;
   end

endmodule

// File: sv/burgers_element_jacobian_top.sv
// Top level of the Burgers element Jacobian block: front queue, Gauss-point
// pipeline and output bank. Depends on bej_pkg, bej_ifs and the macro header.
//
//   Channel  Dir  Word                                        Handshake
//   req_ch   in   node_u0..3, elem_width, elem_duration       valid/ready
//   rsp_ch   out  row, col, entry_value, last                 valid/ready
//
// In steady state the pipeline takes one Gauss point per cycle unless stalled,
// and the output bank sends one entry per cycle while rsp_ch is ready.
// The first entry is offered once the element has left the queue, all 16 points
// have been issued and the last has passed the pipeline stages into the bank.
// Reset is synchronous and clears the queue, the valid bits and the counters.
// A stalled rsp_ch holds the pipeline only when a finished element needs the
// bank; the two-entry queue still takes words until it is full, and then
// req_ch stalls.
`include "burgers_element_jacobian_top_macros.svh"

module burgers_element_jacobian_top #(
   parameter int QueueDepth = bej_pkg::QueueDepth
) (
   input  logic      clock,
   input  logic      reset,
   bej_req_if.sink   req_ch,
   bej_rsp_if.source rsp_ch
);

   logic                   q_valid;
   bej_pkg::elem_type      q_elem;
   logic                   pop;
   logic                   bank_free;
   logic                   adv;
   bej_pkg::bank_load_type bank_ld;

   // The front queue decouples acceptance from the pipeline.
   bej_front #(.Depth(QueueDepth)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .pop     (pop),
      .q_valid (q_valid),
      .q_elem  (q_elem)
   );

   // The pipeline retires the 16th point of an element straight into the bank.
   bej_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_elem    (q_elem),
      .pop       (pop),
      .bank_free (bank_free),
      .bank_ld   (bank_ld),
      .adv       (adv)
   );

   bej_drain u_drain (
      .clock     (clock),
      .reset     (reset),
      .bank_ld   (bank_ld),
      .bank_free (bank_free),
      .rsp_ch    (rsp_ch)
   );

   // The pipeline only stalls while the bank still holds words to send.
   `BEJ_ASSERT_NOW(a_stall_needs_drain, clock, reset, !adv, rsp_ch.valid,
                   "stall without drain")
   // After the last word of an element, any next word starts a new element.
   `BEJ_ASSERT_NEXT(a_restart_after_last, clock, reset,
                    rsp_ch.valid && rsp_ch.ready && rsp_ch.last,
                    !rsp_ch.valid || (rsp_ch.row == 2'd0 && rsp_ch.col == 2'd0),
                    "bad restart")
   // The bank comes out of reset empty.
   `BEJ_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), !rsp_ch.valid,
                      "valid after reset")

endmodule
